// File: hdl/failsafe_setpoint_supervisor_macros.svh
// Assertion macros shared by the setpoint supervisor RTL.
// Depends on nothing; expects clk and arst_n in the including scope.
`ifndef FAILSAFE_SETPOINT_SUPERVISOR_MACROS_SVH
`define FAILSAFE_SETPOINT_SUPERVISOR_MACROS_SVH

// same-cycle implication, masked during reset
`define FSS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("setpoint supervisor check failed");

// next-cycle implication, masked during reset
`define FSS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("setpoint supervisor check failed");

`endif

// File: hdl/fss_pkg.sv
// Shared types, widths and constants for the failsafe setpoint supervisor.
// No dependencies.
package fss_pkg;

	localparam int ALT_W       = 20;
	localparam int VEL_W       = 16;
	localparam int VZ_W        = 14;
	localparam int TGT_W       = 19;
	localparam int TMO_W       = 8;
	localparam int WARM_W      = 16;
	localparam int AGE_W       = 8;
	localparam int TICK_W      = 16;
	localparam int REQ_AGE_W   = 6;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 19;

	localparam int ALT_MARGIN_MM     = 150;
	localparam int BACKOFF_TICKS_DEF = 40;

	// reset values of the configuration registers
	localparam logic [TGT_W-1:0]  TGT_RST  = TGT_W'(2000);
	localparam logic [VZ_W-1:0]   SPD_RST  = VZ_W'(600);
	localparam logic [TMO_W-1:0]  TMO_RST  = TMO_W'(10);
	localparam logic [WARM_W-1:0] WARM_RST = WARM_W'(120);

	typedef enum logic [1:0] {
		ACT_STATUS   = 2'd0,
		ACT_ODOMETRY = 2'd1,
		ACT_CONTROL  = 2'd2,
		ACT_TICK     = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		MODE_TAKEOFF = 2'd0,
		MODE_CRUISE  = 2'd1,
		MODE_HOVER   = 2'd2
	} drive_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET_ALT = 2'd0,
		REG_TAKEOFF_SPD = 2'd1,
		REG_CMD_TIMEOUT = 2'd2,
		REG_WARMUP      = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [TGT_W-1:0]  target_alt;
		logic [VZ_W-1:0]   takeoff_spd;
		logic [TMO_W-1:0]  cmd_timeout;
		logic [WARM_W-1:0] warmup;
	} cfg_t;

	typedef struct packed {
		logic signed [VEL_W-1:0] vel_x;
		logic signed [VEL_W-1:0] vel_y;
		logic [VZ_W-1:0]         vel_z;
		logic signed [VEL_W-1:0] yaw_rate;
		drive_mode_t             mode;
		logic                    req_offboard;
		logic                    req_arm;
	} result_t;

endpackage

// File: hdl/fss_cfg.sv
// Configuration register bank of the setpoint supervisor.
// Depends on fss_pkg.
module fss_cfg
	import fss_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// register writes, each truncated to its field width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_alt  <= TGT_RST;
			cfg_q.takeoff_spd <= SPD_RST;
			cfg_q.cmd_timeout <= TMO_RST;
			cfg_q.warmup      <= WARM_RST;
		end else if (wr_en) begin
			unique case (cfg_reg_t'(wr_index))
				REG_TARGET_ALT:  cfg_q.target_alt  <= wr_data[TGT_W-1:0];
				REG_TAKEOFF_SPD: cfg_q.takeoff_spd <= wr_data[VZ_W-1:0];
				REG_CMD_TIMEOUT: cfg_q.cmd_timeout <= wr_data[TMO_W-1:0];
				REG_WARMUP:      cfg_q.warmup      <= wr_data[WARM_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hdl/fss_core.sv
// Supervisor state and the per-event update, including setpoint choice on a tick.
// Depends on fss_pkg and the assertion macro header.
`include "failsafe_setpoint_supervisor_macros.svh"

module fss_core
	import fss_pkg::*;
#(
	parameter int BACKOFF_TICKS = BACKOFF_TICKS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  action_t                 action,
	input  logic                    link_connected,
	input  logic                    is_armed,
	input  logic                    is_offboard,
	input  logic signed [ALT_W-1:0] altitude_mm,
	input  logic signed [VEL_W-1:0] cmd_vel_x,
	input  logic signed [VEL_W-1:0] cmd_vel_y,
	input  logic signed [VEL_W-1:0] cmd_yaw_rate,
	input  cfg_t                    cfg,
	output result_t                 result
);

	localparam logic [REQ_AGE_W-1:0] BACKOFF = REQ_AGE_W'(BACKOFF_TICKS);
	localparam logic signed [ALT_W:0] MARGIN = (ALT_W+1)'(ALT_MARGIN_MM);

	logic                    link_up_q, armed_q, offboard_q;
	logic                    have_odo_q, have_ctrl_q, req_once_q;
	logic signed [ALT_W-1:0] alt_q;
	logic signed [VEL_W-1:0] held_vx_q, held_vy_q, held_yaw_q;
	logic [AGE_W-1:0]        ctrl_age_q;
	logic [TICK_W-1:0]       ticks_q;
	logic [REQ_AGE_W-1:0]    req_age_q;

	logic                    tick;
	logic [REQ_AGE_W-1:0]    req_age_inc;
	logic [AGE_W-1:0]        ctrl_age_inc;
	logic [TICK_W-1:0]       ticks_inc;
	logic signed [ALT_W:0]   alt_limit;
	logic                    below_target, fresh, fire, any_req;

	assign tick = step && (action == ACT_TICK);

	// saturating counters as seen after this tick
	assign req_age_inc  = (req_once_q && (req_age_q != '1)) ? req_age_q + 1'b1 : req_age_q;
	assign ctrl_age_inc = (ctrl_age_q != '1) ? ctrl_age_q + 1'b1 : ctrl_age_q;
	assign ticks_inc    = (ticks_q != '1) ? ticks_q + 1'b1 : ticks_q;

	// mode decision: target minus margin, compared signed one bit wider
	assign alt_limit    = $signed({2'b00, cfg.target_alt}) - MARGIN;
	assign below_target = $signed({alt_q[ALT_W-1], alt_q}) < alt_limit;
	assign fresh        = have_ctrl_q && (ctrl_age_q <= cfg.cmd_timeout);

	// request gate and choice
	assign fire    = (ticks_inc >= cfg.warmup) && link_up_q
	                 && (!req_once_q || (req_age_inc >= BACKOFF));
	assign any_req = fire && (!offboard_q || !armed_q);

	// setpoint for the current tick
	always_comb begin
		result              = '0;
		result.mode         = MODE_HOVER;
		result.req_offboard = fire && !offboard_q;
		result.req_arm      = fire && offboard_q && !armed_q;
		if (!have_odo_q || below_target) begin
			result.mode  = MODE_TAKEOFF;
			result.vel_z = cfg.takeoff_spd;
		end else if (fresh) begin
			result.mode     = MODE_CRUISE;
			result.vel_x    = held_vx_q;
			result.vel_y    = held_vy_q;
			result.yaw_rate = held_yaw_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_up_q   <= 1'b0;
			armed_q     <= 1'b0;
			offboard_q  <= 1'b0;
			have_odo_q  <= 1'b0;
			have_ctrl_q <= 1'b0;
			req_once_q  <= 1'b0;
			alt_q       <= '0;
			held_vx_q   <= '0;
			held_vy_q   <= '0;
			held_yaw_q  <= '0;
			ctrl_age_q  <= '0;
			ticks_q     <= '0;
			req_age_q   <= '0;
		end else if (step) begin
			unique case (action)
				ACT_STATUS: begin
					link_up_q  <= link_connected;
					armed_q    <= is_armed;
					offboard_q <= is_offboard;
				end
				ACT_ODOMETRY: begin
					alt_q      <= altitude_mm;
					have_odo_q <= 1'b1;
				end
				ACT_CONTROL: begin
					held_vx_q   <= cmd_vel_x;
					held_vy_q   <= cmd_vel_y;
					held_yaw_q  <= cmd_yaw_rate;
					ctrl_age_q  <= '0;
					have_ctrl_q <= 1'b1;
				end
				ACT_TICK: begin
					ctrl_age_q <= ctrl_age_inc;
					ticks_q    <= ticks_inc;
					if (any_req) begin
						req_once_q <= 1'b1;
						req_age_q  <= '0;
					end else begin
						req_age_q <= req_age_inc;
					end
				end
				default: ;
			endcase
		end
	end

	// a request on a tick restarts the backoff
	`FSS_ASSERT_NEXT(a_req_restarts_backoff, tick && any_req, req_once_q && (req_age_q == '0))

endmodule

// File: hdl/fss_out.sv
// Result register with valid/ready towards the consumer.
// Depends on fss_pkg.
module fss_out
	import fss_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t load_data,
	input  logic    ready,
	output logic    valid,
	output logic    free,
	output result_t data
);

	logic    valid_q;
	result_t data_q;

	assign free = !valid_q || ready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (free && load) begin
			data_q <= load_data;
		end
	end

	assign valid = valid_q;
	assign data  = data_q;

endmodule

// File: hdl/failsafe_setpoint_supervisor.sv
// Failsafe setpoint supervisor, top level: input register, state core, result register.
// Depends on fss_pkg, fss_cfg, fss_core, fss_out and the assertion macro header.
//
// Usage: each item on the in_ channel is one event (status, odometry, control
// command or tick) and is taken when in_valid and in_ready are both high.
// Only a tick produces a word on the out_ channel: the velocity setpoint,
// drive mode and the offboard/arm request bits. Other events just update
// the held state.
// Flow: an accepted item is registered in the input register, then processed
// by the state core; a tick's result is registered in the result register.
// Throughput: one item per cycle unless a tick waits on a stalled result
// register, set by the state update between the input and result registers.
// When the consumer stalls, the result register holds its word; one more
// tick may wait in the input register, after which in_ready drops. A status,
// odometry or control event in the input register never waits on the output.
// Configuration: cfg_ writes are always accepted (cfg_ready is high) and
// take effect the next cycle; write only while the block is idle.
// Reset (arst_n low, asynchronous): all held state clears, the registers
// return to their defaults and both valids drop.
`include "failsafe_setpoint_supervisor_macros.svh"

module failsafe_setpoint_supervisor
	import fss_pkg::*;
#(
	parameter int BACKOFF_TICKS = BACKOFF_TICKS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// event channel
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   action,
	input  logic                         link_connected,
	input  logic                         is_armed,
	input  logic                         is_offboard,
	input  logic signed [ALT_W-1:0]      altitude_mm,
	input  logic signed [VEL_W-1:0]      cmd_vel_x,
	input  logic signed [VEL_W-1:0]      cmd_vel_y,
	input  logic signed [VEL_W-1:0]      cmd_yaw_rate,
	// setpoint channel
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [VEL_W-1:0]      out_vel_x,
	output logic signed [VEL_W-1:0]      out_vel_y,
	output logic [VZ_W-1:0]              out_vel_z,
	output logic signed [VEL_W-1:0]      out_yaw_rate,
	output logic [1:0]                   drive_mode,
	output logic                         request_offboard,
	output logic                         request_arm,
	// configuration write channel
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data
);

	logic                    valid_s1;
	action_t                 action_s1;
	logic                    link_s1, armed_s1, offb_s1;
	logic signed [ALT_W-1:0] alt_s1;
	logic signed [VEL_W-1:0] vx_s1, vy_s1, yaw_s1;

	logic    advance, out_free, in_take;
	cfg_t    cfg;
	result_t res, res_out;

	// stage 1 moves on unless it holds a tick and the result register is full
	assign advance  = valid_s1 && ((action_s1 != ACT_TICK) || out_free);
	assign in_ready = !valid_s1 || advance;
	assign in_take  = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// input register, valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// input register, payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			action_s1 <= action_t'(action);
			link_s1   <= link_connected;
			armed_s1  <= is_armed;
			offb_s1   <= is_offboard;
			alt_s1    <= altitude_mm;
			vx_s1     <= cmd_vel_x;
			vy_s1     <= cmd_vel_y;
			yaw_s1    <= cmd_yaw_rate;
		end
	end

	fss_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	fss_core #(
		.BACKOFF_TICKS (BACKOFF_TICKS)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.action         (action_s1),
		.link_connected (link_s1),
		.is_armed       (armed_s1),
		.is_offboard    (offb_s1),
		.altitude_mm    (alt_s1),
		.cmd_vel_x      (vx_s1),
		.cmd_vel_y      (vy_s1),
		.cmd_yaw_rate   (yaw_s1),
		.cfg            (cfg),
		.result         (res)
	);

	fss_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && (action_s1 == ACT_TICK)),
		.load_data (res),
		.ready     (out_ready),
		.valid     (out_valid),
		.free      (out_free),
		.data      (res_out)
	);

	assign out_vel_x        = res_out.vel_x;
	assign out_vel_y        = res_out.vel_y;
	assign out_vel_z        = res_out.vel_z;
	assign out_yaw_rate     = res_out.yaw_rate;
	assign drive_mode       = res_out.mode;
	assign request_offboard = res_out.req_offboard;
	assign request_arm      = res_out.req_arm;

	// only a waiting tick behind a stalled result may hold off new input
	`FSS_ASSERT_SAME(a_stall_only_on_tick, !in_ready,
		valid_s1 && (action_s1 == ACT_TICK) && out_valid && !out_ready)
	// velocities pass through only in cruise
	`FSS_ASSERT_SAME(a_idle_axes_zero, out_valid && (drive_mode != MODE_CRUISE),
		(out_vel_x == '0) && (out_vel_y == '0) && (out_yaw_rate == '0))
	// climb only during takeoff
	`FSS_ASSERT_SAME(a_climb_only_takeoff, out_valid && (drive_mode != MODE_TAKEOFF),
		out_vel_z == '0)
	// at most one request per tick
	`FSS_ASSERT_SAME(a_one_request, out_valid, !(request_offboard && request_arm))
	// a tick that moves on always lands in the result register
	`FSS_ASSERT_NEXT(a_tick_lands, advance && (action_s1 == ACT_TICK), out_valid)

endmodule

// File: verif/testbench.sv
// Self-checking testbench for failsafe_setpoint_supervisor: events go in over valid/ready,
// setpoint words are scored against a behavioural predictor of the supervisor.
// Depends on fss_pkg and the RTL under hdl/.
module testbench
	import fss_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ALT_MAX       = 2**(ALT_W-1) - 1;
	localparam int ALT_MIN       = -(2**(ALT_W-1));
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES   = 8;
	localparam int REPORT_LIMIT  = 10;
	localparam int SAT_ITEMS     = 320;

	// one event as driven on the input channel
	typedef struct {
		action_t                 act;
		logic                    link;
		logic                    armed;
		logic                    offb;
		logic signed [ALT_W-1:0] alt;
		logic signed [VEL_W-1:0] vx;
		logic signed [VEL_W-1:0] vy;
		logic signed [VEL_W-1:0] yaw;
	} event_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic [1:0]              action;
	logic                    link_connected;
	logic                    is_armed;
	logic                    is_offboard;
	logic signed [ALT_W-1:0] altitude_mm;
	logic signed [VEL_W-1:0] cmd_vel_x;
	logic signed [VEL_W-1:0] cmd_vel_y;
	logic signed [VEL_W-1:0] cmd_yaw_rate;
	logic                    out_valid;
	logic                    out_ready;
	logic signed [VEL_W-1:0] out_vel_x;
	logic signed [VEL_W-1:0] out_vel_y;
	logic [VZ_W-1:0]         out_vel_z;
	logic signed [VEL_W-1:0] out_yaw_rate;
	logic [1:0]              drive_mode;
	logic                    request_offboard;
	logic                    request_arm;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;

	// predictor state: configuration and the supervisor's held values
	cfg_t                    regs;
	logic                    seen_link, seen_armed, seen_offboard;
	logic                    odo_valid, cmd_valid, asked_once;
	logic signed [ALT_W-1:0] alt_held;
	logic signed [VEL_W-1:0] hold_vx, hold_vy, hold_yaw;
	logic [AGE_W-1:0]        cmd_age;
	logic [TICK_W-1:0]       ticks_seen;
	logic [REQ_AGE_W-1:0]    ask_age;

	result_t expected_setpoints [$];
	int      failures   = 0;
	bit      idle_ok    = 1'b1;
	int      stall_left = 0;

	failsafe_setpoint_supervisor dut (.*);

	always #10 clk = ~clk;

	// predictor: update held state for one accepted event, queue the setpoint for a tick
	function automatic void supervise_event(input event_t ev);
		result_t sp;
		int      floor_mm;
		case (ev.act)
		ACT_STATUS: begin
			seen_link     = ev.link;
			seen_armed    = ev.armed;
			seen_offboard = ev.offb;
		end
		ACT_ODOMETRY: begin
			alt_held  = ev.alt;
			odo_valid = 1'b1;
		end
		ACT_CONTROL: begin
			hold_vx   = ev.vx;
			hold_vy   = ev.vy;
			hold_yaw  = ev.yaw;
			cmd_age   = '0;
			cmd_valid = 1'b1;
		end
		default: begin
			sp = '0;
			if (asked_once && ask_age != '1)
				ask_age++;
			// mode choice
			floor_mm = int'(regs.target_alt) - ALT_MARGIN_MM;
			if (!odo_valid || int'(alt_held) < floor_mm) begin
				sp.mode  = MODE_TAKEOFF;
				sp.vel_z = regs.takeoff_spd;
			end else if (cmd_valid && cmd_age <= regs.cmd_timeout) begin
				sp.mode     = MODE_CRUISE;
				sp.vel_x    = hold_vx;
				sp.vel_y    = hold_vy;
				sp.yaw_rate = hold_yaw;
			end else
				sp.mode = MODE_HOVER;
			if (cmd_age != '1)
				cmd_age++;
			if (ticks_seen != '1)
				ticks_seen++;
			// offboard first, then arming, spaced by the backoff
			if (ticks_seen >= regs.warmup && seen_link &&
					(!asked_once || int'(ask_age) >= BACKOFF_TICKS_DEF)) begin
				sp.req_offboard = !seen_offboard;
				sp.req_arm      = seen_offboard && !seen_armed;
				if (sp.req_offboard || sp.req_arm) begin
					asked_once = 1'b1;
					ask_age    = '0;
				end
			end
			expected_setpoints.push_back(sp);
		end
		endcase
	endfunction

	// event with every field random; the event then overrides what it uses
	function automatic event_t noise_event(input action_t act);
		event_t ev;
		ev.act   = act;
		ev.link  = 1'($urandom_range(0, 1));
		ev.armed = 1'($urandom_range(0, 1));
		ev.offb  = 1'($urandom_range(0, 1));
		ev.alt   = ALT_W'($urandom);
		ev.vx    = VEL_W'($urandom);
		ev.vy    = VEL_W'($urandom);
		ev.yaw   = VEL_W'($urandom);
		return ev;
	endfunction

	function automatic event_t status_event(input logic link, input logic armed,
			input logic offb);
		event_t ev;
		ev       = noise_event(ACT_STATUS);
		ev.link  = link;
		ev.armed = armed;
		ev.offb  = offb;
		return ev;
	endfunction

	function automatic event_t odo_event(input int mm);
		event_t ev;
		ev     = noise_event(ACT_ODOMETRY);
		ev.alt = ALT_W'(mm);
		return ev;
	endfunction

	function automatic event_t ctl_event(input int x, input int y, input int yaw);
		event_t ev;
		ev     = noise_event(ACT_CONTROL);
		ev.vx  = VEL_W'(x);
		ev.vy  = VEL_W'(y);
		ev.yaw = VEL_W'(yaw);
		return ev;
	endfunction

	// weighted mix; half the altitudes cluster around the takeoff threshold
	function automatic event_t random_event(input int w_tick, input int w_ctl);
		int r, floor_mm, alt;
		r = $urandom_range(0, 99);
		if (r < w_tick)
			return noise_event(ACT_TICK);
		if (r < w_tick + w_ctl)
			return noise_event(ACT_CONTROL);
		if (r % 2 == 0)
			return status_event($urandom_range(0, 5) != 0, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
		floor_mm = int'(regs.target_alt) - ALT_MARGIN_MM;
		case ($urandom_range(0, 3))
		0, 1: alt = floor_mm + int'($urandom_range(0, 600)) - 300;
		2: alt = int'($signed(ALT_W'($urandom)));
		default: alt = $urandom_range(0, 1) ? ALT_MAX : ALT_MIN;
		endcase
		if (alt > ALT_MAX)
			alt = ALT_MAX;
		if (alt < ALT_MIN)
			alt = ALT_MIN;
		return odo_event(alt);
	endfunction

	function automatic cfg_t random_settings();
		cfg_t s;
		case ($urandom_range(0, 3))
		0: s.target_alt = '0;
		1: s.target_alt = '1;
		2: s.target_alt = TGT_W'($urandom);
		default: s.target_alt = TGT_W'($urandom_range(100, 5000));
		endcase
		case ($urandom_range(0, 2))
		0: s.takeoff_spd = '0;
		1: s.takeoff_spd = VZ_W'(10000);
		default: s.takeoff_spd = VZ_W'($urandom_range(0, 10000));
		endcase
		case ($urandom_range(0, 3))
		0: s.cmd_timeout = '0;
		1: s.cmd_timeout = '1;
		2: s.cmd_timeout = TMO_W'($urandom_range(0, 40));
		default: s.cmd_timeout = TMO_W'($urandom);
		endcase
		case ($urandom_range(0, 3))
		0: s.warmup = '0;
		1: s.warmup = '1;
		2: s.warmup = WARM_W'($urandom_range(0, 60));
		default: s.warmup = WARM_W'($urandom_range(0, 300));
		endcase
		return s;
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			failures++;
			if (failures <= REPORT_LIMIT)
				$display("mismatch on %s: expected %0d, got %0d", name, want, got);
		end
	endfunction

	// send one event word, optionally after an idle burst, and predict on acceptance
	task automatic push_event(input event_t ev);
		if (idle_ok && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid       <= 1'b1;
		action         <= ev.act;
		link_connected <= ev.link;
		is_armed       <= ev.armed;
		is_offboard    <= ev.offb;
		altitude_mm    <= ev.alt;
		cmd_vel_x      <= ev.vx;
		cmd_vel_y      <= ev.vy;
		cmd_yaw_rate   <= ev.yaw;
		do @(posedge clk); while (!in_ready);
		supervise_event(ev);
	endtask

	// drain: all setpoints in, then a settling wait for events that give none
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_setpoints.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write all four registers, with junk above each narrower register's width
	task automatic program_regs(input cfg_t s);
		cfg_reg_t              order [4];
		logic [CFG_DATA_W-1:0] word;
		order = '{REG_TARGET_ALT, REG_TAKEOFF_SPD, REG_CMD_TIMEOUT, REG_WARMUP};
		foreach (order[i]) begin
			word = CFG_DATA_W'($urandom);
			case (order[i])
			REG_TARGET_ALT: word = s.target_alt;
			REG_TAKEOFF_SPD: word[VZ_W-1:0] = s.takeoff_spd;
			REG_CMD_TIMEOUT: word[TMO_W-1:0] = s.cmd_timeout;
			default: word[WARM_W-1:0] = s.warmup;
			endcase
			cfg_valid <= 1'b1;
			cfg_index <= order[i];
			cfg_data  <= word;
			do @(posedge clk); while (!cfg_ready);
			case (order[i])
			REG_TARGET_ALT: regs.target_alt = word[TGT_W-1:0];
			REG_TAKEOFF_SPD: regs.takeoff_spd = word[VZ_W-1:0];
			REG_CMD_TIMEOUT: regs.cmd_timeout = word[TMO_W-1:0];
			default: regs.warmup = word[WARM_W-1:0];
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	// zero warmup from reset: offboard asked on the very first tick, then backoff
	task automatic test_request_gating();
		program_regs('{target_alt: TGT_W'(2150), takeoff_spd: VZ_W'(600),
			cmd_timeout: TMO_W'(255), warmup: '0});
		push_event(status_event(1'b1, 1'b0, 1'b0));
		push_event(noise_event(ACT_TICK));
		push_event(status_event(1'b1, 1'b0, 1'b1));
		push_event(noise_event(ACT_TICK));
		// offboard and armed: nothing to ask for
		push_event(status_event(1'b1, 1'b1, 1'b1));
		push_event(noise_event(ACT_TICK));
		push_event(status_event(1'b0, 1'b0, 1'b0));
	endtask

	// takeoff threshold edges, command freshness with zero timeout, field extremes
	task automatic test_mode_selection();
		wait_idle();
		program_regs('{target_alt: TGT_W'(2150), takeoff_spd: VZ_W'(10000),
			cmd_timeout: '0, warmup: '1});
		push_event(noise_event(ACT_TICK));
		push_event(odo_event(1999));
		push_event(noise_event(ACT_TICK));
		push_event(odo_event(2000));
		push_event(noise_event(ACT_TICK));
		push_event(ctl_event(-32768, 32767, -1));
		push_event(noise_event(ACT_TICK));
		push_event(noise_event(ACT_TICK));
		push_event(ctl_event(32767, -32768, 32767));
		push_event(odo_event(ALT_MAX));
		push_event(noise_event(ACT_TICK));
		push_event(odo_event(ALT_MIN));
		push_event(noise_event(ACT_TICK));
	endtask

	// zero target puts the threshold below ground; zero climb speed
	task automatic test_low_target();
		wait_idle();
		program_regs('{target_alt: '0, takeoff_spd: '0, cmd_timeout: '1, warmup: '1});
		push_event(odo_event(-ALT_MARGIN_MM));
		push_event(noise_event(ACT_TICK));
		push_event(odo_event(-ALT_MARGIN_MM - 1));
		push_event(noise_event(ACT_TICK));
	endtask

	// phases of random traffic, each under fresh settings
	task automatic test_random_phases();
		int w_tick, w_ctl;
		for (int phase = 0; phase < 10; phase++) begin
			wait_idle();
			program_regs(random_settings());
			idle_ok = (phase % 4 != 3);
			w_tick  = $urandom_range(40, 70);
			w_ctl   = ($urandom_range(0, 2) == 0) ? 1 : 15;
			repeat (150) push_event(random_event(w_tick, w_ctl));
		end
	endtask

	// back-to-back ticks with no stalls: the held command ages out to its ceiling
	// and stays fresh at the largest timeout, requests keep their backoff
	task automatic test_tick_saturation();
		cfg_t s;
		wait_idle();
		idle_ok       = 1'b0;
		s.target_alt  = TGT_W'($urandom_range(0, 5000));
		s.takeoff_spd = VZ_W'($urandom_range(0, 10000));
		s.cmd_timeout = '1;
		s.warmup      = WARM_W'($urandom_range(0, 60));
		program_regs(s);
		push_event(odo_event(ALT_MAX));
		push_event(ctl_event(int'($signed(VEL_W'($urandom))),
			int'($signed(VEL_W'($urandom))), int'($signed(VEL_W'($urandom)))));
		push_event(status_event(1'b1, 1'b0, 1'b0));
		repeat (SAT_ITEMS) begin
			if ($urandom_range(0, 49) == 0)
				push_event(status_event($urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1))));
			else
				push_event(noise_event(ACT_TICK));
		end
	endtask

	// receiver: random stall bursts while idling is allowed
	always @(posedge clk) begin
		if (!idle_ok) begin
			stall_left = 0;
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= (stall_left == 0);
		end else if ($urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(1, 11);
			out_ready <= 1'b0;
		end else
			out_ready <= 1'b1;
	end

	// score each setpoint word against the oldest expectation
	always @(posedge clk) begin : score_setpoints
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_setpoints.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("setpoint word arrived with none expected");
			end else begin
				want = expected_setpoints.pop_front();
				check_field("out_vel_x", want.vel_x, out_vel_x);
				check_field("out_vel_y", want.vel_y, out_vel_y);
				check_field("out_vel_z", want.vel_z, out_vel_z);
				check_field("out_yaw_rate", want.yaw_rate, out_yaw_rate);
				check_field("drive_mode", want.mode, drive_mode);
				check_field("request_offboard", want.req_offboard, request_offboard);
				check_field("request_arm", want.req_arm, request_arm);
			end
		end
	end

	initial begin
		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		action         <= ACT_STATUS;
		link_connected <= 1'b0;
		is_armed       <= 1'b0;
		is_offboard    <= 1'b0;
		altitude_mm    <= '0;
		cmd_vel_x      <= '0;
		cmd_vel_y      <= '0;
		cmd_yaw_rate   <= '0;
		out_ready      <= 1'b1;
		cfg_valid      <= 1'b0;
		cfg_index      <= REG_TARGET_ALT;
		cfg_data       <= '0;
		// predictor reset state
		regs          = '{target_alt: TGT_RST, takeoff_spd: SPD_RST,
			cmd_timeout: TMO_RST, warmup: WARM_RST};
		seen_link     = 1'b0;
		seen_armed    = 1'b0;
		seen_offboard = 1'b0;
		odo_valid     = 1'b0;
		cmd_valid     = 1'b0;
		asked_once    = 1'b0;
		alt_held      = '0;
		hold_vx       = '0;
		hold_vy       = '0;
		hold_yaw      = '0;
		cmd_age       = '0;
		ticks_seen    = '0;
		ask_age       = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_request_gating();
		test_mode_selection();
		test_low_target();
		test_random_phases();
		test_tick_saturation();

		in_valid <= 1'b0;
		while (expected_setpoints.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// watchdog
	initial begin
		#20_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// File: failsafe_setpoint_supervisor.f
+incdir+hdl
hdl/fss_pkg.sv
hdl/fss_cfg.sv
hdl/fss_core.sv
hdl/fss_out.sv
hdl/failsafe_setpoint_supervisor.sv
verif/testbench.sv
